[rtl/core/tmft_pkg.sv]
// tmft_pkg: shared types and constants of the tetrahedral mesh facet table
// used by tmft_prep, tmft_cell and tetra_mesh_facet_table_top; no dependencies
`default_nettype none

package tmft_pkg;

  // default sizing
  localparam int unsigned TMFT_DEPTH_DEF = 256;
  localparam int unsigned TMFT_VB_DEF    = 32;

  // fixed field widths of the ports
  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned READ_IDX_W  = 8;
  localparam int unsigned COUNT_OUT_W = 9;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned STATUS_W    = 2;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // facet mode codes, the unused code acts as boundary mode
  typedef enum logic [MODE_W-1:0] {
    MODE_UNORIENTED = 2'd0,
    MODE_ORIENTED   = 2'd1,
    MODE_BOUNDARY   = 2'd2
  } mode_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DROPPED = 2'd1,
    STATUS_RANGE   = 2'd2
  } status_e;

  // position of a vertex inside a facet triple
  typedef logic [1:0] slot_t;
  localparam slot_t SLOT_FIRST  = 2'd0;
  localparam slot_t SLOT_SECOND = 2'd1;
  localparam slot_t SLOT_THIRD  = 2'd2;

  // what a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_TAKE_LEFT  = 2'd1,
    CELL_TAKE_NEW   = 2'd2,
    CELL_TAKE_RIGHT = 2'd3
  } cell_op_e;

  // per-cell control from the row controller
  typedef struct packed {
    cell_op_e op;
    logic     oriented;
  } cell_ctrl_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PREP  = 2'd1,
    ST_APPLY = 2'd2,
    ST_RESP  = 2'd3
  } state_e;

endpackage

`default_nettype wire

[rtl/core/tmft_prep.sv]
// tmft_prep: picks one facet of the current tetrahedron and registers it
// together with its sorted key and the sorting permutation; uses tmft_pkg
`default_nettype none

module tmft_prep #(
  parameter int unsigned VERTEX_BITS = tmft_pkg::TMFT_VB_DEF
) (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic [1:0]                          sel_i,
  input  logic [3:0][VERTEX_BITS-1:0]         vertex_i,
  output logic [2:0][VERTEX_BITS-1:0]         raw_o,
  output tmft_pkg::slot_t [2:0]               perm_o,
  output logic [2:0][VERTEX_BITS-1:0]         key_o
);
  import tmft_pkg::*;

  logic [2:0][VERTEX_BITS-1:0] facet;
  logic [2:0][VERTEX_BITS-1:0] sa, sb, sc;
  slot_t [2:0]                 pa, pb, pc;
  logic                        swap_a, swap_b, swap_c;

  logic [2:0][VERTEX_BITS-1:0] raw_q, key_q;
  slot_t [2:0]                 perm_q;

  // facet order (v1,v2,v4), (v1,v4,v3), (v3,v4,v2), (v1,v2,v3)
  always_comb begin
    case (sel_i)
      2'd0:    facet = {vertex_i[3], vertex_i[1], vertex_i[0]};
      2'd1:    facet = {vertex_i[2], vertex_i[3], vertex_i[0]};
      2'd2:    facet = {vertex_i[1], vertex_i[3], vertex_i[2]};
      default: facet = {vertex_i[2], vertex_i[1], vertex_i[0]};
    endcase
  end

  // three compare-swaps, slot tags follow the values
  assign swap_a = facet[0] > facet[1];
  assign sa[0]  = swap_a ? facet[1] : facet[0];
  assign sa[1]  = swap_a ? facet[0] : facet[1];
  assign sa[2]  = facet[2];
  assign pa[0]  = swap_a ? SLOT_SECOND : SLOT_FIRST;
  assign pa[1]  = swap_a ? SLOT_FIRST : SLOT_SECOND;
  assign pa[2]  = SLOT_THIRD;

  assign swap_b = sa[1] > sa[2];
  assign sb[0]  = sa[0];
  assign sb[1]  = swap_b ? sa[2] : sa[1];
  assign sb[2]  = swap_b ? sa[1] : sa[2];
  assign pb[0]  = pa[0];
  assign pb[1]  = swap_b ? pa[2] : pa[1];
  assign pb[2]  = swap_b ? pa[1] : pa[2];

  assign swap_c = sb[0] > sb[1];
  assign sc[0]  = swap_c ? sb[1] : sb[0];
  assign sc[1]  = swap_c ? sb[0] : sb[1];
  assign sc[2]  = sb[2];
  assign pc[0]  = swap_c ? pb[1] : pb[0];
  assign pc[1]  = swap_c ? pb[0] : pb[1];
  assign pc[2]  = pb[2];

  // facet register feeding the cell row
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      raw_q  <= facet;
      key_q  <= sc;
      perm_q <= pc;
    end
  end

  assign raw_o  = raw_q;
  assign key_o  = key_q;
  assign perm_o = perm_q;

endmodule

`default_nettype wire

[rtl/core/tmft_cell.sv]
// tmft_cell: one slot of the ordered facet row; holds a facet and its sort
// permutation, compares its key with the broadcast facet; uses tmft_pkg
`default_nettype none

module tmft_cell #(
  parameter int unsigned VERTEX_BITS = tmft_pkg::TMFT_VB_DEF
) (
  input  logic                                clk_i,
  input  tmft_pkg::cell_ctrl_t                ctrl_i,
  input  logic [2:0][VERTEX_BITS-1:0]         new_raw_i,
  input  tmft_pkg::slot_t [2:0]               new_perm_i,
  input  logic [2:0][VERTEX_BITS-1:0]         left_raw_i,
  input  tmft_pkg::slot_t [2:0]               left_perm_i,
  input  logic [2:0][VERTEX_BITS-1:0]         right_raw_i,
  input  tmft_pkg::slot_t [2:0]               right_perm_i,
  input  logic [2:0][VERTEX_BITS-1:0]         t_key_i,
  output logic [2:0][VERTEX_BITS-1:0]         raw_o,
  output tmft_pkg::slot_t [2:0]               perm_o,
  output logic                                gt_o,
  output logic                                eq_o
);
  import tmft_pkg::*;

  logic [2:0][VERTEX_BITS-1:0] raw_q;
  slot_t [2:0]                 perm_q;
  logic [2:0][VERTEX_BITS-1:0] sorted;
  logic [2:0][VERTEX_BITS-1:0] key;
  logic [3*VERTEX_BITS-1:0]    key_cat, t_cat;

  // sorted key rebuilt from the stored permutation
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (perm_q[k])
        SLOT_SECOND: sorted[k] = raw_q[1];
        SLOT_THIRD:  sorted[k] = raw_q[2];
        default:     sorted[k] = raw_q[0];
      endcase
    end
  end

  // lexicographic compare, first vertex most significant
  assign key     = ctrl_i.oriented ? raw_q : sorted;
  assign key_cat = {key[0], key[1], key[2]};
  assign t_cat   = {t_key_i[0], t_key_i[1], t_key_i[2]};
  assign gt_o    = key_cat > t_cat;
  assign eq_o    = key_cat == t_cat;

  // shift, load or hold
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      CELL_HOLD: begin
        raw_q  <= raw_q;
        perm_q <= perm_q;
      end
      CELL_TAKE_LEFT: begin
        raw_q  <= left_raw_i;
        perm_q <= left_perm_i;
      end
      CELL_TAKE_NEW: begin
        raw_q  <= new_raw_i;
        perm_q <= new_perm_i;
      end
      CELL_TAKE_RIGHT: begin
        raw_q  <= right_raw_i;
        perm_q <= right_perm_i;
      end
    endcase
  end

  assign raw_o  = raw_q;
  assign perm_o = perm_q;

endmodule

`default_nettype wire

[rtl/core/tetra_mesh_facet_table_top.sv]
// tetra_mesh_facet_table_top: sequencer, cell row and result register of the
// facet table; uses tmft_pkg, tmft_prep and tmft_cell
`default_nettype none

// Ordered facet table for tetrahedral meshes. An add beat applies the four
// facets of a tetrahedron one per cycle to a row of TABLE_DEPTH cells that
// keep the facets sorted by key; every cell compares against the broadcast
// facet and the row shifts by one place to insert or remove. An add runs a
// facet setup state, four facet passes through the cell row and a result
// state; clear and read go straight to the result state, which waits while
// an earlier result is still held. The four dependent passes through the
// shared cell row set the add time. A read returns the facet of the given
// rank in key order, selected straight from the row. Stored count and
// overflow flag clear on reset; the facet storage itself needs no clearing
// pass, only entries below the count are ever read. The mode register
// must be written only while the block is idle; it is not enforced here.
module tetra_mesh_facet_table_top #(
  parameter int unsigned TABLE_DEPTH = tmft_pkg::TMFT_DEPTH_DEF,
  parameter int unsigned VERTEX_BITS = tmft_pkg::TMFT_VB_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tmft_pkg::MODE_W-1:0]          cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [tmft_pkg::CMD_W-1:0]           command_i,
  input  logic [tmft_pkg::FIELD_W-1:0]         vertex_first_i,
  input  logic [tmft_pkg::FIELD_W-1:0]         vertex_second_i,
  input  logic [tmft_pkg::FIELD_W-1:0]         vertex_third_i,
  input  logic [tmft_pkg::FIELD_W-1:0]         vertex_fourth_i,
  input  logic [tmft_pkg::READ_IDX_W-1:0]      read_index_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [tmft_pkg::STATUS_W-1:0]        status_o,
  output logic [tmft_pkg::FIELD_W-1:0]         facet_a_o,
  output logic [tmft_pkg::FIELD_W-1:0]         facet_b_o,
  output logic [tmft_pkg::FIELD_W-1:0]         facet_c_o,
  output logic [tmft_pkg::COUNT_OUT_W-1:0]     entry_count_o,
  output logic                                 overflow_seen_o
);
  import tmft_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > READ_IDX_W) ? CNT_W : READ_IDX_W;

  // sequencer
  state_e                      state_q, state_d;
  logic [1:0]                  step_q;
  logic                        in_accept, prep_load, apply_en, resp_load;

  // captured beat
  logic [CMD_W-1:0]            cmd_q;
  logic [3:0][VERTEX_BITS-1:0] vtx_q;
  logic [READ_IDX_W-1:0]       idx_q;

  // table state
  logic [MODE_W-1:0]           mode_q;
  logic [CNT_W-1:0]            count_q;
  logic                        ovf_q;
  logic                        drop_q;

  // result register
  logic                        out_valid_q;
  status_e                     out_status_q;
  logic [VERTEX_BITS-1:0]      out_fa_q, out_fb_q, out_fc_q;
  logic [COUNT_OUT_W-1:0]      out_count_q;
  logic                        out_ovf_q;

  // prepared facet
  logic [2:0][VERTEX_BITS-1:0] prep_raw, prep_key, t_key;
  slot_t [2:0]                 prep_perm;

  // cell row
  logic [2:0][VERTEX_BITS-1:0] cell_raw  [TABLE_DEPTH];
  slot_t [2:0]                 cell_perm [TABLE_DEPTH];
  cell_ctrl_t                  cell_ctrl [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]      cell_gt, cell_eq, cell_valid;
  logic [TABLE_DEPTH-1:0]      gt_v, eq_v, ge_pos, ge_prev, rem_mask;

  logic                        oriented, toggle, found, full;
  logic                        do_ins, do_rem, do_drop;
  logic                        in_range;
  logic [2:0][VERTEX_BITS-1:0] rd_raw;

  assign in_accept = in_valid_i & in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (cmd_e'(command_i) == CMD_ADD) ? ST_PREP : ST_RESP;
        end
      end
      ST_PREP: begin
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        // step wraps to zero on the fourth facet
        if (step_q == 2'd0) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    prep_load  = 1'b0;
    apply_en   = 1'b0;
    resp_load  = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_PREP:  prep_load  = 1'b1;
      ST_APPLY: begin
        prep_load = 1'b1;
        apply_en  = 1'b1;
      end
      ST_RESP:  resp_load  = !out_valid_q || out_ready_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        step_q <= 2'd0;
      end else if (prep_load) begin
        step_q <= step_q + 2'd1;
      end
    end
  end

  // beat capture, vertices cut to the id width
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q    <= command_i;
      vtx_q[0] <= vertex_first_i[VERTEX_BITS-1:0];
      vtx_q[1] <= vertex_second_i[VERTEX_BITS-1:0];
      vtx_q[2] <= vertex_third_i[VERTEX_BITS-1:0];
      vtx_q[3] <= vertex_fourth_i[VERTEX_BITS-1:0];
      idx_q    <= read_index_i;
    end
  end

  // facet setup stage
  tmft_prep #(
    .VERTEX_BITS (VERTEX_BITS)
  ) u_prep (
    .clk_i    (clk_i),
    .load_i   (prep_load),
    .sel_i    (step_q),
    .vertex_i (vtx_q),
    .raw_o    (prep_raw),
    .perm_o   (prep_perm),
    .key_o    (prep_key)
  );

  // mode decode, the unused code toggles like boundary mode
  assign oriented = (mode_q == MODE_ORIENTED);
  assign toggle   = (mode_q != MODE_UNORIENTED) && (mode_q != MODE_ORIENTED);
  assign t_key    = oriented ? prep_raw : prep_key;

  // row-wide decisions for the facet in flight
  assign found   = |eq_v;
  assign full    = (count_q == CNT_W'(TABLE_DEPTH));
  assign do_ins  = apply_en && !found && !full;
  assign do_rem  = apply_en && found && toggle;
  assign do_drop = apply_en && !found && full;

  // cell row with per-cell shift control
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [2:0][VERTEX_BITS-1:0] left_raw, right_raw;
    slot_t [2:0]                 left_perm, right_perm;

    assign cell_valid[i] = CNT_W'(i) < count_q;
    assign gt_v[i]       = cell_gt[i] & cell_valid[i];
    assign eq_v[i]       = cell_eq[i] & cell_valid[i];
    // at or past the insert point, and first match onward
    assign ge_pos[i]     = (|gt_v[i:0]) | ~cell_valid[i];
    assign rem_mask[i]   = |eq_v[i:0];

    if (i == 0) begin : g_first
      assign ge_prev[i] = 1'b0;
      assign left_raw   = prep_raw;
      assign left_perm  = prep_perm;
    end else begin : g_rest
      assign ge_prev[i] = ge_pos[i-1];
      assign left_raw   = cell_raw[i-1];
      assign left_perm  = cell_perm[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_raw  = cell_raw[i];
      assign right_perm = cell_perm[i];
    end else begin : g_mid
      assign right_raw  = cell_raw[i+1];
      assign right_perm = cell_perm[i+1];
    end

    always_comb begin
      cell_ctrl[i].oriented = oriented;
      if (do_ins && ge_pos[i]) begin
        cell_ctrl[i].op = ge_prev[i] ? CELL_TAKE_LEFT : CELL_TAKE_NEW;
      end else if (do_rem && rem_mask[i]) begin
        cell_ctrl[i].op = CELL_TAKE_RIGHT;
      end else begin
        cell_ctrl[i].op = CELL_HOLD;
      end
    end

    tmft_cell #(
      .VERTEX_BITS (VERTEX_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl[i]),
      .new_raw_i    (prep_raw),
      .new_perm_i   (prep_perm),
      .left_raw_i   (left_raw),
      .left_perm_i  (left_perm),
      .right_raw_i  (right_raw),
      .right_perm_i (right_perm),
      .t_key_i      (t_key),
      .raw_o        (cell_raw[i]),
      .perm_o       (cell_perm[i]),
      .gt_o         (cell_gt[i]),
      .eq_o         (cell_eq[i])
    );
  end

  // mode register, count and sticky overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_UNORIENTED;
      count_q <= '0;
      ovf_q   <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        drop_q <= 1'b0;
      end else if (do_drop) begin
        drop_q <= 1'b1;
      end
      if (do_ins) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_rem) begin
        count_q <= count_q - CNT_W'(1);
      end else if (resp_load && (cmd_q == CMD_CLEAR)) begin
        count_q <= '0;
      end
      if (do_drop) begin
        ovf_q <= 1'b1;
      end else if (resp_load && (cmd_q == CMD_CLEAR)) begin
        ovf_q <= 1'b0;
      end
    end
  end

  // read select across the row
  assign in_range = CMP_W'(idx_q) < CMP_W'(count_q);

  always_comb begin
    rd_raw = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (CMP_W'(idx_q) == CMP_W'(i)) begin
        rd_raw = rd_raw | cell_raw[i];
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (resp_load) begin
      out_fa_q     <= '0;
      out_fb_q     <= '0;
      out_fc_q     <= '0;
      out_status_q <= STATUS_OK;
      out_count_q  <= COUNT_OUT_W'(count_q);
      out_ovf_q    <= ovf_q;
      unique case (cmd_e'(cmd_q))
        CMD_CLEAR: begin
          out_count_q <= '0;
          out_ovf_q   <= 1'b0;
        end
        CMD_ADD: begin
          if (drop_q) begin
            out_status_q <= STATUS_DROPPED;
          end
        end
        CMD_READ: begin
          if (in_range) begin
            out_fa_q <= rd_raw[0];
            out_fb_q <= rd_raw[1];
            out_fc_q <= rd_raw[2];
          end else begin
            out_status_q <= STATUS_RANGE;
          end
        end
        default: begin
          out_status_q <= STATUS_OK;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign facet_a_o       = FIELD_W'(out_fa_q);
  assign facet_b_o       = FIELD_W'(out_fb_q);
  assign facet_c_o       = FIELD_W'(out_fc_q);
  assign entry_count_o   = out_count_q;
  assign overflow_seen_o = out_ovf_q;

endmodule

`default_nettype wire
